/* hw/rtl/sqvs_pkg.sv */
// Types, constants and helper functions for the sprite quad vertex setup unit.
`default_nettype none
package sqvs_pkg;

	localparam int TEXTURE_ID_BITS = 8;
	localparam int COORD_FRAC_BITS = 8;
	localparam int CORDIC_STEPS    = 14;
	localparam int DIV_STEPS       = 17;
	localparam int CORDIC_GAIN     = 39797;
	localparam int UV_ONE          = 65536;
	localparam int ZOOM_MIN        = 410;
	localparam int ZOOM_MAX        = 32768;
	localparam int VP_SHIFT        = COORD_FRAC_BITS + 28;

	typedef struct packed {
		logic [TEXTURE_ID_BITS-1:0] texture_id;
		logic [25:0]                tex_size;
		logic [12:0]                src_x;
		logic [12:0]                src_y;
		logic [12:0]                src_w;
		logic [12:0]                src_h;
		logic signed [23:0]         dest_x;
		logic signed [23:0]         dest_y;
		logic [22:0]                dest_w;
		logic [22:0]                dest_h;
		logic [15:0]                angle;
		logic [31:0]                color;
	} sprite_t;

	typedef struct packed {
		logic [1:0]         corner;
		logic signed [23:0] screen_x;
		logic signed [23:0] screen_y;
		logic [16:0]        tex_u;
		logic [16:0]        tex_v;
		logic [31:0]        vertex_color;
		logic               batch_start;
		logic               last;
	} vertex_t;

	typedef struct packed {
		logic signed [23:0] center_x;
		logic signed [23:0] center_y;
		logic signed [23:0] shake_x;
		logic signed [23:0] shake_y;
		logic [15:0]        zoom;
		logic [13:0]        viewport_width;
		logic [13:0]        viewport_height;
	} cfg_t;

	typedef struct packed {
		sprite_t sprite;
		logic    start;
	} cmd_t;

	typedef enum logic [2:0] {
		REG_CENTER_X        = 3'd0,
		REG_CENTER_Y        = 3'd1,
		REG_SHAKE_X         = 3'd2,
		REG_SHAKE_Y         = 3'd3,
		REG_ZOOM            = 3'd4,
		REG_VIEWPORT_WIDTH  = 3'd5,
		REG_VIEWPORT_HEIGHT = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_MUL,
		ST_SUM,
		ST_SCALE,
		ST_EMIT
	} back_state_t;

	function automatic logic [13:0] atan_step(input logic [3:0] i);
		logic [13:0] r;
		case (i)
			4'd0:    r = 14'd8192;
			4'd1:    r = 14'd4836;
			4'd2:    r = 14'd2555;
			4'd3:    r = 14'd1297;
			4'd4:    r = 14'd651;
			4'd5:    r = 14'd326;
			4'd6:    r = 14'd163;
			4'd7:    r = 14'd81;
			4'd8:    r = 14'd41;
			4'd9:    r = 14'd20;
			4'd10:   r = 14'd10;
			4'd11:   r = 14'd5;
			4'd12:   r = 14'd3;
			4'd13:   r = 14'd1;
			default: r = 14'd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [17:0] clamp_unit(input logic signed [19:0] v);
		logic signed [17:0] r;
		if (v > 20'sd65536)
			r = 18'sd65536;
		else if (v < -20'sd65536)
			r = -18'sd65536;
		else
			r = 18'(v);
		return r;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/sqvs_front.sv */
// Front end: accepts sprites, drops missing textures, marks batch starts, two-entry queue.
`default_nettype none
module sqvs_front (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                sprite_valid,
	output logic               sprite_stall,
	input  sqvs_pkg::sprite_t  sprite,
	output logic               q_valid,
	output sqvs_pkg::cmd_t     q_entry,
	input  wire                q_pop
);
	import sqvs_pkg::*;

	logic [TEXTURE_ID_BITS-1:0] prev_tex_q;
	logic                       have_prev_q;
	logic [1:0]                 count_q;
	logic                       wr_ptr_q;
	logic                       rd_ptr_q;
	cmd_t                       slot0_q;
	cmd_t                       slot1_q;
	logic                       push;
	cmd_t                       entry;

	assign sprite_stall = (count_q == 2'd2);
	assign q_valid      = (count_q != 2'd0);
	assign q_entry      = rd_ptr_q ? slot1_q : slot0_q;

	assign push = sprite_valid && !sprite_stall && (sprite.texture_id != '0);

	always_comb begin
		entry.sprite = sprite;
		entry.start  = !have_prev_q || (sprite.texture_id != prev_tex_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_tex_q  <= '0;
			have_prev_q <= 1'b0;
			count_q     <= 2'd0;
			wr_ptr_q    <= 1'b0;
			rd_ptr_q    <= 1'b0;
		end else begin
			if (push) begin
				prev_tex_q  <= sprite.texture_id;
				have_prev_q <= 1'b1;
				wr_ptr_q    <= !wr_ptr_q;
			end
			if (q_pop && q_valid)
				rd_ptr_q <= !rd_ptr_q;
			case ({push, q_pop && q_valid})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push && !wr_ptr_q)
			slot0_q <= entry;
		if (push && wr_ptr_q)
			slot1_q <= entry;
	end

endmodule
`default_nettype wire

/* hw/rtl/sqvs_back.sv */
// Back end: CORDIC, texture divides, and the per-corner transform sequencer.
`default_nettype none
module sqvs_back (
	input  wire                clk,
	input  wire                arst_n,
	input  sqvs_pkg::cfg_t     cfg,
	input  wire                q_valid,
	input  sqvs_pkg::cmd_t     q_entry,
	output logic               q_pop,
	output logic               vertex_valid,
	input  wire                vertex_stall,
	output sqvs_pkg::vertex_t  vertex
);
	import sqvs_pkg::*;

	back_state_t state_q, next_state;
	logic [4:0]  cnt_q;
	logic [1:0]  corner_q;
	cmd_t        cmd_q;

	logic signed [19:0] cx_q, cy_q;
	logic signed [16:0] cz_q;
	logic signed [17:0] cos_q, sin_q;

	logic [13:0] rem_q [4];
	logic [16:0] low_q [4];
	logic [12:0] den_q [4];
	logic        sat_q [4];
	logic [16:0] satv_q [4];

	logic signed [26:0] ex_q, ey_q;
	logic [15:0]        zm_q;
	logic [13:0]        vpw_q, vph_q;

	logic signed [41:0] pxc_s1, pys_s1, pxs_s1, pyc_s1;
	logic signed [44:0] dx_s2, dy_s2;
	logic [38:0]        lox_s3, loy_s3;
	logic signed [38:0] hix_s3, hiy_s3;

	logic    out_valid_q;
	vertex_t out_q;
	logic    out_free;
	logic    emit;

	// decode of a new sprite at the queue head
	sprite_t     hs;
	logic [13:0] num_w [4];
	logic [12:0] den_w [4];
	logic [30:0] n_w [4];
	logic [15:0] zm_w;

	// per-cycle datapath
	logic [3:0]         ci;
	logic signed [19:0] sh_x, sh_y;
	logic signed [16:0] at_w;
	logic signed [17:0] xc_w, yc_w, c_w, s_w;
	logic signed [23:0] ox_w, oy_w;
	logic [14:0]        t_w [4];
	logic [16:0]        uv_w [4];
	logic signed [63:0] vx_w, vy_w, rx_w, ry_w;
	logic signed [23:0] scr_x, scr_y;

	assign out_free     = !out_valid_q || !vertex_stall;
	assign vertex_valid = out_valid_q;
	assign vertex       = out_q;

	always_comb begin
		next_state = state_q;
		case (state_q)
			ST_IDLE:  if (q_valid) next_state = ST_SETUP;
			ST_SETUP: if (cnt_q == 5'(DIV_STEPS - 1)) next_state = ST_MUL;
			ST_MUL:   next_state = ST_SUM;
			ST_SUM:   next_state = ST_SCALE;
			ST_SCALE: next_state = ST_EMIT;
			ST_EMIT: begin
				if (out_free)
					next_state = (corner_q == 2'd3) ? ST_IDLE : ST_MUL;
			end
			default:  next_state = ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop = (state_q == ST_IDLE) && q_valid;
		emit  = (state_q == ST_EMIT) && out_free;
	end

	always_comb begin
		hs = q_entry.sprite;
		num_w[0] = {1'b0, hs.src_x};
		num_w[1] = {1'b0, hs.src_x} + {1'b0, hs.src_w};
		num_w[2] = {1'b0, hs.src_y};
		num_w[3] = {1'b0, hs.src_y} + {1'b0, hs.src_h};
		den_w[0] = hs.tex_size[25:13];
		den_w[1] = hs.tex_size[25:13];
		den_w[2] = hs.tex_size[12:0];
		den_w[3] = hs.tex_size[12:0];
		for (int k = 0; k < 4; k++)
			n_w[k] = {1'b0, num_w[k], 16'b0} + 31'(den_w[k][12:1]);
		if (cfg.zoom < 16'(ZOOM_MIN))
			zm_w = 16'(ZOOM_MIN);
		else if (cfg.zoom > 16'(ZOOM_MAX))
			zm_w = 16'(ZOOM_MAX);
		else
			zm_w = cfg.zoom;
	end

	always_comb begin
		ci   = cnt_q[3:0];
		sh_x = cy_q >>> ci;
		sh_y = cx_q >>> ci;
		at_w = $signed({3'b0, atan_step(ci)});
		xc_w = clamp_unit(cx_q);
		yc_w = clamp_unit(cy_q);
		case (cmd_q.sprite.angle[15:14])
			2'd0:    begin c_w = xc_w;  s_w = yc_w;  end
			2'd1:    begin c_w = -yc_w; s_w = xc_w;  end
			2'd2:    begin c_w = -xc_w; s_w = -yc_w; end
			default: begin c_w = yc_w;  s_w = -xc_w; end
		endcase
		ox_w = (corner_q == 2'd0 || corner_q == 2'd3) ?
			-$signed({1'b0, cmd_q.sprite.dest_w}) : $signed({1'b0, cmd_q.sprite.dest_w});
		oy_w = (corner_q[1] == 1'b0) ?
			-$signed({1'b0, cmd_q.sprite.dest_h}) : $signed({1'b0, cmd_q.sprite.dest_h});
		for (int k = 0; k < 4; k++) begin
			t_w[k]  = {rem_q[k], low_q[k][16]};
			uv_w[k] = sat_q[k] ? satv_q[k] : low_q[k];
		end
		vx_w = (64'(hix_s3) <<< 23) + $signed(64'(lox_s3))
			+ ($signed(64'(vpw_q)) <<< VP_SHIFT) + 64'sd268435456;
		vy_w = (64'(hiy_s3) <<< 23) + $signed(64'(loy_s3))
			+ ($signed(64'(vph_q)) <<< VP_SHIFT) + 64'sd268435456;
		rx_w = vx_w >>> 29;
		ry_w = vy_w >>> 29;
		if (rx_w > 64'sd8388607)
			scr_x = 24'sh7FFFFF;
		else if (rx_w < -64'sd8388608)
			scr_x = 24'sh800000;
		else
			scr_x = 24'(rx_w);
		if (ry_w > 64'sd8388607)
			scr_y = 24'sh7FFFFF;
		else if (ry_w < -64'sd8388608)
			scr_y = 24'sh800000;
		else
			scr_y = 24'(ry_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= 5'd0;
			corner_q    <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= next_state;
			if (q_pop)
				cnt_q <= 5'd0;
			else if (state_q == ST_SETUP)
				cnt_q <= cnt_q + 5'd1;
			if (q_pop)
				corner_q <= 2'd0;
			else if (emit)
				corner_q <= corner_q + 2'd1;
			if (emit)
				out_valid_q <= 1'b1;
			else if (!vertex_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_entry;
			cx_q  <= 20'(CORDIC_GAIN);
			cy_q  <= '0;
			cz_q  <= $signed({3'b0, hs.angle[13:0]});
			ex_q  <= (27'(hs.dest_x) <<< 1) + $signed({4'b0, hs.dest_w})
				- (27'(cfg.center_x) <<< 1) + (27'(cfg.shake_x) <<< 1);
			ey_q  <= (27'(hs.dest_y) <<< 1) + $signed({4'b0, hs.dest_h})
				- (27'(cfg.center_y) <<< 1) + (27'(cfg.shake_y) <<< 1);
			zm_q  <= zm_w;
			vpw_q <= (cfg.viewport_width == '0) ? 14'd1 : cfg.viewport_width;
			vph_q <= (cfg.viewport_height == '0) ? 14'd1 : cfg.viewport_height;
			for (int k = 0; k < 4; k++) begin
				rem_q[k] <= n_w[k][30:17];
				low_q[k] <= n_w[k][16:0];
				den_q[k] <= den_w[k];
				if (den_w[k] == '0) begin
					sat_q[k]  <= 1'b1;
					satv_q[k] <= (num_w[k] != '0) ? 17'(UV_ONE) : 17'd0;
				end else begin
					sat_q[k]  <= (num_w[k] >= {1'b0, den_w[k]});
					satv_q[k] <= 17'(UV_ONE);
				end
			end
		end else if (state_q == ST_SETUP) begin
			if (cnt_q < 5'(CORDIC_STEPS)) begin
				if (!cz_q[16]) begin
					cx_q <= cx_q - sh_x;
					cy_q <= cy_q + sh_y;
					cz_q <= cz_q - at_w;
				end else begin
					cx_q <= cx_q + sh_x;
					cy_q <= cy_q - sh_y;
					cz_q <= cz_q + at_w;
				end
			end
			for (int k = 0; k < 4; k++) begin
				if (t_w[k] >= {2'b0, den_q[k]}) begin
					rem_q[k] <= 14'(t_w[k] - {2'b0, den_q[k]});
					low_q[k] <= {low_q[k][15:0], 1'b1};
				end else begin
					rem_q[k] <= t_w[k][13:0];
					low_q[k] <= {low_q[k][15:0], 1'b0};
				end
			end
			cos_q <= c_w;
			sin_q <= s_w;
		end

		if (state_q == ST_MUL) begin
			pxc_s1 <= 42'(ox_w) * 42'(cos_q);
			pys_s1 <= 42'(oy_w) * 42'(sin_q);
			pxs_s1 <= 42'(ox_w) * 42'(sin_q);
			pyc_s1 <= 42'(oy_w) * 42'(cos_q);
		end
		if (state_q == ST_SUM) begin
			dx_s2 <= (45'(ex_q) <<< 16) + 45'(pxc_s1) - 45'(pys_s1);
			dy_s2 <= (45'(ey_q) <<< 16) + 45'(pxs_s1) + 45'(pyc_s1);
		end
		if (state_q == ST_SCALE) begin
			lox_s3 <= {16'b0, dx_s2[22:0]} * {23'b0, zm_q};
			loy_s3 <= {16'b0, dy_s2[22:0]} * {23'b0, zm_q};
			hix_s3 <= 39'($signed(dx_s2[44:23])) * $signed({23'b0, zm_q});
			hiy_s3 <= 39'($signed(dy_s2[44:23])) * $signed({23'b0, zm_q});
		end
		if (emit) begin
			out_q.corner       <= corner_q;
			out_q.screen_x     <= scr_x;
			out_q.screen_y     <= scr_y;
			out_q.tex_u        <= (corner_q == 2'd1 || corner_q == 2'd2) ? uv_w[1] : uv_w[0];
			out_q.tex_v        <= corner_q[1] ? uv_w[3] : uv_w[2];
			out_q.vertex_color <= cmd_q.sprite.color;
			out_q.batch_start  <= (corner_q == 2'd0) && cmd_q.start;
			out_q.last         <= (corner_q == 2'd3);
		end
	end

	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.last |-> out_q.corner == 2'd3)
		else $error("last flag on a corner other than the fourth");

	a_start_corner: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.batch_start |-> out_q.corner == 2'd0)
		else $error("batch start on a corner other than the first");

	a_uv_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.tex_u <= 17'(UV_ONE) && out_q.tex_v <= 17'(UV_ONE))
		else $error("texture coordinate above one");

	a_pop_setup: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q == ST_SETUP && cnt_q == 5'd0)
		else $error("queue pop did not start setup");

endmodule
`default_nettype wire

/* hw/rtl/sprite_quad_vertex_setup_unit.sv */
// Top level: configuration registers, front end and back end of the sprite vertex setup.
// Usage:
//   sprite channel: one sprite command per transaction (sprite_valid / sprite_stall).
//   Sprites whose texture_id is zero are accepted and dropped without output.
//   vertex channel: four transactions per sprite, corners TL, TR, BR, BL; last marks BL.
//   cfg channel: cfg_index selects a register, cfg_data carries the value; cfg_ready
//   is always high. Write only while no sprite is in flight.
// Operation:
//   The back end holds one sprite at a time: a pop, then setup by the bit-serial
//   texture divider (the 14-step CORDIC runs alongside), then each corner in turn
//   through multiply, sum, scale and output register. It pops no new sprite until
//   the fourth vertex of the current one has been taken into the output register.
//   A two-entry queue between front and back lets sprites be accepted while the
//   back end works; sprite_stall rises when it is full.
// Reset: configuration returns to its defaults (zoom 1.0, 1920 x 1080), the queue
//   empties and the first sprite after reset always starts a batch.
// Stall: while vertex_stall is high the held vertex stays put and the back end
//   waits after finishing its next corner.
`default_nettype none
module sprite_quad_vertex_setup_unit (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                sprite_valid,
	output logic               sprite_stall,
	input  sqvs_pkg::sprite_t  sprite,
	output logic               vertex_valid,
	input  wire                vertex_stall,
	output sqvs_pkg::vertex_t  vertex,
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire  [2:0]         cfg_index,
	input  wire  [23:0]        cfg_data
);
	import sqvs_pkg::*;

	cfg_t cfg_q;
	logic q_valid;
	cmd_t q_entry;
	logic q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x        <= '0;
			cfg_q.center_y        <= '0;
			cfg_q.shake_x         <= '0;
			cfg_q.shake_y         <= '0;
			cfg_q.zoom            <= 16'd4096;
			cfg_q.viewport_width  <= 14'd1920;
			cfg_q.viewport_height <= 14'd1080;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_CENTER_X:        cfg_q.center_x        <= cfg_data;
				REG_CENTER_Y:        cfg_q.center_y        <= cfg_data;
				REG_SHAKE_X:         cfg_q.shake_x         <= cfg_data;
				REG_SHAKE_Y:         cfg_q.shake_y         <= cfg_data;
				REG_ZOOM:            cfg_q.zoom            <= cfg_data[15:0];
				REG_VIEWPORT_WIDTH:  cfg_q.viewport_width  <= cfg_data[13:0];
				REG_VIEWPORT_HEIGHT: cfg_q.viewport_height <= cfg_data[13:0];
				default: ;
			endcase
		end
	end

	sqvs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sprite_valid (sprite_valid),
		.sprite_stall (sprite_stall),
		.sprite       (sprite),
		.q_valid      (q_valid),
		.q_entry      (q_entry),
		.q_pop        (q_pop)
	);

	sqvs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (q_valid),
		.q_entry      (q_entry),
		.q_pop        (q_pop),
		.vertex_valid (vertex_valid),
		.vertex_stall (vertex_stall),
		.vertex       (vertex)
	);

endmodule
`default_nettype wire

/* tb/tb_sprite_quad_vertex_setup_unit.sv */
// Testbench for the sprite quad vertex setup unit: directed and random sprites.
`timescale 1ns / 1ps
`default_nettype none
module tb_sprite_quad_vertex_setup_unit;
	import sqvs_pkg::*;

	localparam int ATAN [14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};
	localparam longint LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sprite_valid = 1'b0;
	logic sprite_stall;
	sprite_t sprite = '0;
	logic vertex_valid;
	logic vertex_stall = 1'b0;
	vertex_t vertex;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;

	sprite_quad_vertex_setup_unit uut (
		.clk(clk), .arst_n(arst_n),
		.sprite_valid(sprite_valid), .sprite_stall(sprite_stall), .sprite(sprite),
		.vertex_valid(vertex_valid), .vertex_stall(vertex_stall), .vertex(vertex),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	longint cam_cx, cam_cy, cam_sx, cam_sy;
	int unsigned cam_zoom, vp_w, vp_h;
	logic [7:0] prev_tex;
	bit seen_tex;
	vertex_t expected_vertices[$];
	int mismatches = 0;
	longint cycles = 0;
	bit stall_heavy = 1'b0;

	function automatic longint fshift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clampl(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic void rotation(logic [15:0] ang, output longint c, output longint s);
		longint x, y, z, dx, dy;
		x = 39797; y = 0; z = longint'(ang[13:0]);
		for (int i = 0; i < 14; i++) begin
			dx = fshift(y, i);
			dy = fshift(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN[i];
			end else begin
				x += dx; y -= dy; z += ATAN[i];
			end
		end
		x = clampl(x, -65536, 65536);
		y = clampl(y, -65536, 65536);
		case (ang[15:14])
			2'd0: begin c = x; s = y; end
			2'd1: begin c = -y; s = x; end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endfunction

	function automatic logic [16:0] uv_coord(longint num, longint den);
		longint r;
		if (den == 0) return num != 0 ? 17'd65536 : 17'd0;
		r = ((num << 16) + (den >> 1)) / den;
		return r > 65536 ? 17'd65536 : 17'(r);
	endfunction

	function automatic logic [23:0] screen_coord(longint w, longint cen, longint shk,
			longint zm, longint vp);
		longint d, v;
		d = w - (cen - shk) * (longint'(1) << 17);
		v = d * zm + vp * (longint'(1) << 36);
		v = fshift(v + (longint'(1) << 28), 29);
		return 24'(clampl(v, -8388608, 8388607));
	endfunction

	task automatic predict_quad(sprite_t sp);
		longint cx, cy, c, s, dw, dh, ox, oy, zm, vw, vh;
		logic [16:0] u0, u1, v0, v1;
		vertex_t vx;
		bit start;
		if (sp.texture_id == '0) return;
		start = !seen_tex || sp.texture_id != prev_tex;
		prev_tex = sp.texture_id;
		seen_tex = 1'b1;
		u0 = uv_coord(longint'(sp.src_x), longint'(sp.tex_size[25:13]));
		u1 = uv_coord(longint'(sp.src_x) + longint'(sp.src_w), longint'(sp.tex_size[25:13]));
		v0 = uv_coord(longint'(sp.src_y), longint'(sp.tex_size[12:0]));
		v1 = uv_coord(longint'(sp.src_y) + longint'(sp.src_h), longint'(sp.tex_size[12:0]));
		dw = longint'(sp.dest_w); dh = longint'(sp.dest_h);
		cx = 2 * longint'(sp.dest_x) + dw;
		cy = 2 * longint'(sp.dest_y) + dh;
		rotation(sp.angle, c, s);
		zm = clampl(longint'(cam_zoom), longint'(ZOOM_MIN), longint'(ZOOM_MAX));
		vw = vp_w == 0 ? 1 : longint'(vp_w);
		vh = vp_h == 0 ? 1 : longint'(vp_h);
		for (int i = 0; i < 4; i++) begin
			ox = (i == 0 || i == 3) ? -dw : dw;
			oy = (i < 2) ? -dh : dh;
			vx.corner = 2'(i);
			vx.screen_x = screen_coord(cx * 65536 + ox * c - oy * s, cam_cx, cam_sx, zm, vw);
			vx.screen_y = screen_coord(cy * 65536 + ox * s + oy * c, cam_cy, cam_sy, zm, vh);
			vx.tex_u = (i == 1 || i == 2) ? u1 : u0;
			vx.tex_v = (i >= 2) ? v1 : v0;
			vx.vertex_color = sp.color;
			vx.batch_start = (i == 0) && start;
			vx.last = (i == 3);
			expected_vertices = {expected_vertices, vx};
		end
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(negedge clk)
		vertex_stall <= stall_heavy ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 5) == 0);

	always @(posedge clk) begin
		if (arst_n && vertex_valid && !vertex_stall) begin
			if (expected_vertices.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected vertex %p", vertex);
			end else begin
				vertex_t e;
				e = expected_vertices.pop_front();
				if (vertex !== e) begin
					mismatches++;
					if (mismatches <= 10) $display("vertex mismatch: exp %p got %p", e, vertex);
				end
			end
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [23:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_CENTER_X: cam_cx = longint'(signed'(val));
			REG_CENTER_Y: cam_cy = longint'(signed'(val));
			REG_SHAKE_X: cam_sx = longint'(signed'(val));
			REG_SHAKE_Y: cam_sy = longint'(signed'(val));
			REG_ZOOM: cam_zoom = 32'(val[15:0]);
			REG_VIEWPORT_WIDTH: vp_w = 32'(val[13:0]);
			REG_VIEWPORT_HEIGHT: vp_h = 32'(val[13:0]);
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic send_sprite(sprite_t sp);
		sprite_valid <= 1'b1;
		sprite <= sp;
		do @(posedge clk); while (sprite_stall);
		predict_quad(sp);
		@(negedge clk);
	endtask

	task automatic sprite_idle(int n);
		sprite_valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic drain;
		int guard;
		guard = 0;
		sprite_valid <= 1'b0;
		while (expected_vertices.size() != 0 && guard < 200000) begin
			@(negedge clk);
			guard++;
		end
		repeat (60) @(negedge clk);
	endtask

	function automatic sprite_t random_sprite();
		sprite_t sp;
		sp = sprite_t'($bits(sprite_t)'({$urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom}));
		if ($urandom_range(0, 3) != 0) begin
			sp.tex_size[25:13] = 13'($urandom_range(1, 1024));
			sp.tex_size[12:0] = 13'($urandom_range(1, 1024));
			sp.src_x = 13'($urandom_range(0, sp.tex_size[25:13]));
			sp.src_y = 13'($urandom_range(0, sp.tex_size[12:0]));
			sp.src_w = 13'($urandom_range(0, sp.tex_size[25:13] - sp.src_x));
			sp.src_h = 13'($urandom_range(0, sp.tex_size[12:0] - sp.src_y));
			sp.dest_x = 24'($signed($urandom_range(0, 600000)) - 300000);
			sp.dest_y = 24'($signed($urandom_range(0, 600000)) - 300000);
			sp.dest_w = 23'($urandom_range(0, 100000));
			sp.dest_h = 23'($urandom_range(0, 100000));
			sp.texture_id = 8'($urandom_range(0, 4));
		end
		if ($urandom_range(0, 15) == 0) sp.texture_id = '0;
		return sp;
	endfunction

	task automatic test_directed;
		sprite_t sp;
		sp = '0;
		sp.texture_id = 8'd1; sp.tex_size = {13'd64, 13'd32};
		sp.src_w = 13'd64; sp.src_h = 13'd32;
		sp.dest_w = 23'd8192; sp.dest_h = 23'd4096; sp.color = 32'hFF8040C0;
		send_sprite(sp);
		send_sprite(sp);
		for (int a = 0; a < 8; a++) begin
			sp.angle = 16'(a * 8192 + (a[0] ? 1 : 0));
			send_sprite(sp);
		end
		sp.angle = 16'hFFFF;
		send_sprite(sp);
		sp.texture_id = '0;
		send_sprite(sp);
		sp.texture_id = 8'hFF; sp.tex_size = '0; sp.src_x = '0; sp.src_w = 13'd5;
		send_sprite(sp);
		sp.tex_size = '1; sp.src_x = '1; sp.src_y = '1; sp.src_w = '1; sp.src_h = '1;
		sp.dest_x = 24'h7FFFFF; sp.dest_y = 24'h800000; sp.dest_w = '1; sp.dest_h = '1;
		sp.color = '1;
		send_sprite(sp);
		sp.dest_x = 24'h800000; sp.dest_y = 24'h7FFFFF; sp.angle = 16'h2000;
		send_sprite(sp);
		sp.tex_size = {13'd1, 13'd0}; sp.src_x = '0; sp.src_y = '0; sp.src_w = '0;
		sp.src_h = '0;
		sp.color = '0;
		send_sprite(sp);
		sp.texture_id = 8'h80;
		send_sprite(sp);
		drain();
	endtask

	task automatic test_camera(logic [23:0] cx, logic [23:0] cy, logic [23:0] shx,
			logic [23:0] shy, logic [15:0] zm, logic [13:0] w, logic [13:0] h, int n);
		int gap;
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_SHAKE_X, shx);
		write_reg(REG_SHAKE_Y, shy);
		write_reg(REG_ZOOM, {8'd0, zm});
		write_reg(REG_VIEWPORT_WIDTH, {10'd0, w});
		write_reg(REG_VIEWPORT_HEIGHT, {10'd0, h});
		cfg_valid <= 1'b0;
		while (n > 0) begin
			for (int b = $urandom_range(1, 12); b > 0 && n > 0; b--, n--)
				send_sprite(random_sprite());
			gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 40) : 0;
			if (gap > 0) sprite_idle(gap);
		end
		drain();
	endtask

	initial begin
		cam_cx = 0; cam_cy = 0; cam_sx = 0; cam_sy = 0;
		cam_zoom = 4096; vp_w = 1920; vp_h = 1080;
		prev_tex = 0; seen_tex = 0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_camera(24'd1000, -24'sd2000, 24'd50, -24'sd30, 16'd4096, 14'd1920, 14'd1080, 80);
		test_camera(24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF, 16'd0, 14'd0, 14'd0, 60);
		stall_heavy = 1'b1;
		test_camera(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 16'hFFFF, 14'h3FFF,
			14'h3FFF, 60);
		stall_heavy = 1'b0;
		test_camera(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom), 16'd410,
			14'd1, 14'd8192, 60);
		test_camera(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom), 16'd32768,
			14'd8192, 14'd1, 60);
		test_camera(24'd0, 24'd0, 24'd0, 24'd0, 16'($urandom_range(410, 32768)),
			14'($urandom_range(1, 8192)), 14'($urandom_range(1, 8192)), 95);
		if (mismatches == 0 && expected_vertices.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
`default_nettype wire

/* filelist.f */
hw/rtl/sqvs_pkg.sv
hw/rtl/sqvs_front.sv
hw/rtl/sqvs_back.sv
hw/rtl/sprite_quad_vertex_setup_unit.sv
tb/tb_sprite_quad_vertex_setup_unit.sv
